### rtl/core/tffh_pkg.sv
// ----------------------------------------------------------------------------
// tffh_pkg
// Shared types and constants of the tagged first-fit heap: the block header
// layout, request and result records, operation and status codes and the
// sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tffh_pkg;

  localparam int POOL_CHUNKS      = 128;
  localparam int CHUNK_BYTES      = 32;
  localparam int SPLIT_MIN_CHUNKS = 32;
  localparam int OWNER_W          = 8;
  localparam int MAX_RESULTS      = 64;

  localparam int ADDR_W   = $clog2(POOL_CHUNKS);
  localparam int POOL_W   = ADDR_W + 1;
  localparam int TAG_W    = 7;
  localparam int SIZE_W   = 12;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 3;
  localparam int CHUNK_SH = $clog2(CHUNK_BYTES);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PURGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXT  = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC      = 3'd0,
    ACT_FREE       = 3'd1,
    ACT_FREE_RANGE = 3'd2,
    ACT_CHANGE_TAG = 3'd3,
    ACT_READ_TAG   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_MEM     = 3'd1,
    ST_NOT_BLOCK  = 3'd2,
    ST_BAD_TAG    = 3'd3,
    ST_NEED_OWNER = 3'd4
  } status_e;

  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_OWNER = 1'b1;

  // One header per chunk; a tag of zero marks a free block.
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [ADDR_W-1:0]  size;
    logic [ADDR_W-1:0]  next;
    logic [ADDR_W-1:0]  prev;
    logic [OWNER_W-1:0] owner;
  } header_t;

  localparam int HDR_W = $bits(header_t);

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [SIZE_W-1:0]  size_bytes;
    logic [ADDR_W-1:0]  data_address;
    logic [TAG_W-1:0]   new_tag;
    logic [OWNER_W-1:0] owner_handle;
    logic [TAG_W-1:0]   tag_low;
    logic [TAG_W-1:0]   tag_high;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  address;
    logic [OWNER_W-1:0] owner;
    logic [TAG_W-1:0]   tag;
    logic [STAT_W-1:0]  status;
    logic               last;
  } result_t;

  // Effective (saturated) configuration values.
  typedef struct packed {
    logic [POOL_W-1:0] pool;
    logic [TAG_W-1:0]  purge;
    logic [TAG_W-1:0]  max_tag;
  } cfg_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISPATCH, S_EMIT,
    S_AL_RV, S_AL_PV, S_LP_B, S_LP_FB, S_LP_AFT, S_LP_AF2,
    S_SP_W, S_SP_WN, S_AB_RD, S_AB_W,
    S_FR_B, S_FR_AFT, S_FR_AF2, S_FR_NX,
    S_FIND, S_DONE_OK,
    S_REL_EMIT, S_REL_W0, S_REL_P, S_REL_NPR, S_REL_NPW,
    S_REL_RH, S_REL_H, S_REL_N, S_REL_NNR, S_REL_NNW
  } state_e;

endpackage

`default_nettype wire

### rtl/core/tffh_if.sv
// ----------------------------------------------------------------------------
// tffh_if
// Request and result channels of the heap, each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tffh_req_if;
  import tffh_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [SIZE_W-1:0]  size_bytes;
  logic [ADDR_W-1:0]  data_address;
  logic [TAG_W-1:0]   new_tag;
  logic [OWNER_W-1:0] owner_handle;
  logic [TAG_W-1:0]   tag_low;
  logic [TAG_W-1:0]   tag_high;

  modport source (output valid, action, size_bytes, data_address, new_tag,
                  owner_handle, tag_low, tag_high, input ready);
  modport sink (input valid, action, size_bytes, data_address, new_tag,
                owner_handle, tag_low, tag_high, output ready);
endinterface

interface tffh_rsp_if;
  import tffh_pkg::*;

  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [ADDR_W-1:0]  result_address;
  logic [OWNER_W-1:0] result_owner;
  logic [TAG_W-1:0]   result_tag;
  logic [STAT_W-1:0]  status;
  logic               last;

  modport source (output valid, result_kind, result_address, result_owner,
                  result_tag, status, last, input ready);
  modport sink (input valid, result_kind, result_address, result_owner,
                result_tag, status, last, output ready);
endinterface

`default_nettype wire

### rtl/core/tffh_ram.sv
// ----------------------------------------------------------------------------
// tffh_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tffh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/tffh_seq.sv
// ----------------------------------------------------------------------------
// tffh_seq
// Heap sequencer: walks the block list held in the header memory and
// performs alloc, free, tag-range free and tag access.
// ----------------------------------------------------------------------------
`default_nettype none

module tffh_seq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tffh_pkg::cfg_t             cfg,
  input  wire logic                       restart,
  input  wire logic                       take,
  input  wire tffh_pkg::req_t             req,
  output logic                            idle,
  output logic                            emit_valid,
  output tffh_pkg::result_t               emit,
  input  wire logic                       emit_ready,
  output logic                            ram_we,
  output logic [tffh_pkg::ADDR_W-1:0]     ram_waddr,
  output tffh_pkg::header_t               ram_wdata,
  output logic [tffh_pkg::ADDR_W-1:0]     ram_raddr,
  input  wire tffh_pkg::header_t          ram_rdata
);
  import tffh_pkg::*;

  localparam int GUARD_LIMIT = POOL_CHUNKS * (POOL_CHUNKS + 2);
  localparam int GUARD_W     = $clog2(GUARD_LIMIT + 1);
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam logic [CNT_W-1:0]   OWNER_RES_MAX = CNT_W'(MAX_RESULTS - 1);
  localparam logic [ADDR_W-1:0]  SPLIT_LIM     = ADDR_W'(SPLIT_MIN_CHUNKS + 1);
  localparam logic [ADDR_W-1:0]  CLR_LAST      = ADDR_W'(POOL_CHUNKS - 1);
  localparam logic [GUARD_W-1:0] GUARD_MAX     = GUARD_W'(GUARD_LIMIT);

  state_e              state, state_next, ret, ret_next;
  req_t                op, op_next;
  logic [ADDR_W:0]     chunks, chunks_next;
  logic [ADDR_W-1:0]   blk, blk_next, start_blk, start_next, cur, cur_next;
  logic [ADDR_W-1:0]   sp, sp_next, h, h_next, nx, nx_next, nb, nb_next;
  logic [ADDR_W-1:0]   rover, rover_next, clr_cnt, clr_next;
  logic                split, split_next;
  header_t             hb, hb_next, rd, wr;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [GUARD_W-1:0]  guard, guard_next, guard_inc;
  result_t             c_res, c_res_next;
  logic                purg, fit, in_range;
  logic [ADDR_W-1:0]   extra, extra_hb, sel, da_m1;

  function automatic result_t done_res(status_e st, logic [ADDR_W-1:0] a,
                                       logic [OWNER_W-1:0] o,
                                       logic [TAG_W-1:0] t);
    result_t r;
    r.kind    = KIND_DONE;
    r.address = a;
    r.owner   = o;
    r.tag     = t;
    r.status  = st;
    r.last    = 1'b1;
    return r;
  endfunction

  assign rd        = ram_rdata;
  assign idle      = (state == S_IDLE);
  assign guard_inc = guard + 1'b1;
  assign da_m1     = op.data_address - 1'b1;

  // Tests on the header just read.
  assign purg = rd.valid && rd.tag >= cfg.purge && rd.tag < cfg.max_tag;
  assign fit  = (rd.tag == '0) && ({1'b0, rd.size} >= chunks);
  assign extra    = rd.size - chunks[ADDR_W-1:0];
  assign extra_hb = hb.size - chunks[ADDR_W-1:0];
  assign in_range = rd.valid && rd.tag >= op.tag_low && rd.tag <= op.tag_high &&
                    rd.tag < cfg.max_tag;
  assign sel = (rd.next == cur) ? cur : sp;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      rover   <= '0;
      cnt     <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_next;
      rover   <= rover_next;
      cnt     <= cnt_next;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    ret       <= ret_next;
    op        <= op_next;
    chunks    <= chunks_next;
    blk       <= blk_next;
    start_blk <= start_next;
    cur       <= cur_next;
    sp        <= sp_next;
    h         <= h_next;
    nx        <= nx_next;
    nb        <= nb_next;
    split     <= split_next;
    hb        <= hb_next;
    guard     <= guard_next;
    c_res     <= c_res_next;
  end

  // Next state, memory access and result emission.
  always_comb begin
    state_next = state;
    ret_next   = ret;
    op_next    = op;
    chunks_next = chunks;
    blk_next   = blk;
    start_next = start_blk;
    cur_next   = cur;
    sp_next    = sp;
    h_next     = h;
    nx_next    = nx;
    nb_next    = nb;
    split_next = split;
    hb_next    = hb;
    guard_next = guard;
    c_res_next = c_res;
    rover_next = rover;
    clr_next   = clr_cnt;
    cnt_next   = cnt;
    ram_we     = 1'b0;
    ram_waddr  = h;
    ram_wdata  = rd;
    ram_raddr  = blk;
    emit_valid = 1'b0;
    emit       = c_res;
    wr         = rd;

    case (state)
      S_CLR: begin
        // Clearing pass: entry 0 becomes the single free block.
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (clr_cnt == '0) begin
          ram_wdata.size = ADDR_W'(cfg.pool - 1'b1);
        end
        clr_next = clr_cnt + 1'b1;
        if (clr_cnt == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (take) begin
          op_next     = req;
          chunks_next = (ADDR_W + 1)'(({1'b0, req.size_bytes} +
                        (SIZE_W + 1)'(CHUNK_BYTES - 1)) >> CHUNK_SH);
          cnt_next    = '0;
          state_next  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (op.action)
          ACT_ALLOC: begin
            if (op.new_tag == '0 || op.new_tag >= cfg.max_tag) begin
              c_res_next = done_res(ST_BAD_TAG, '0, '0, '0);
              state_next = S_EMIT;
            end else if (op.new_tag >= cfg.purge && op.owner_handle == '0) begin
              c_res_next = done_res(ST_NEED_OWNER, '0, '0, '0);
              state_next = S_EMIT;
            end else if (op.size_bytes == '0) begin
              c_res_next = done_res(ST_OK, '0, '0, '0);
              state_next = S_EMIT;
            end else begin
              ram_raddr  = rover;
              guard_next = '0;
              state_next = S_AL_RV;
            end
          end
          ACT_FREE_RANGE: begin
            if (op.tag_low == '0) begin
              op_next.tag_low = TAG_W'(1);
            end
            blk_next   = '0;
            ram_raddr  = '0;
            state_next = S_FR_B;
          end
          ACT_FREE, ACT_CHANGE_TAG, ACT_READ_TAG: begin
            if (op.data_address == '0 || {1'b0, da_m1} >= cfg.pool) begin
              c_res_next = done_res(ST_NOT_BLOCK, '0, '0, '0);
              state_next = S_EMIT;
            end else begin
              h_next     = da_m1;
              ram_raddr  = da_m1;
              state_next = S_FIND;
            end
          end
          default: begin
            c_res_next = done_res(ST_OK, '0, '0, '0);
            state_next = S_EMIT;
          end
        endcase
      end

      S_EMIT: begin
        emit_valid = 1'b1;
        emit       = c_res;
        if (emit_ready) begin
          state_next = S_IDLE;
        end
      end

      // Alloc: start at the rover, one block back if that block is free.
      S_AL_RV: begin
        hb_next    = rd;
        blk_next   = rover;
        ram_raddr  = rd.prev;
        state_next = S_AL_PV;
      end

      S_AL_PV: begin
        if (rd.tag == '0) begin
          blk_next   = hb.prev;
          start_next = hb.prev;
          ram_raddr  = hb.prev;
        end else begin
          start_next = blk;
          ram_raddr  = blk;
        end
        state_next = S_LP_B;
      end

      S_LP_B, S_LP_FB: begin
        hb_next = rd;
        if (state == S_LP_B && purg) begin
          sp_next    = rd.prev;
          cur_next   = blk;
          h_next     = blk;
          ret_next   = S_LP_AFT;
          state_next = S_REL_EMIT;
        end else if (fit) begin
          split_next = (extra >= SPLIT_LIM);
          nb_next    = blk + 1'b1 + chunks[ADDR_W-1:0];
          if (extra >= SPLIT_LIM) begin
            state_next = S_SP_W;
          end else begin
            ram_raddr  = blk;
            state_next = S_AB_W;
          end
        end else if (rd.next != start_blk && guard_inc < GUARD_MAX) begin
          blk_next   = rd.next;
          guard_next = guard_inc;
          ram_raddr  = rd.next;
          state_next = S_LP_B;
        end else begin
          c_res_next = done_res(ST_NO_MEM, '0, '0, '0);
          state_next = S_EMIT;
        end
      end

      S_LP_AFT: begin
        ram_raddr  = sp;
        state_next = S_LP_AF2;
      end

      S_LP_AF2: begin
        start_next = sel;
        blk_next   = sel;
        ram_raddr  = sel;
        state_next = S_LP_FB;
      end

      // Split: new free block after the allocated chunks.
      S_SP_W: begin
        ram_we         = 1'b1;
        ram_waddr      = nb;
        ram_wdata      = '0;
        ram_wdata.size = extra_hb - 1'b1;
        ram_wdata.next = hb.next;
        ram_wdata.prev = blk;
        ram_raddr      = hb.next;
        state_next     = S_SP_WN;
      end

      S_SP_WN: begin
        wr         = rd;
        wr.prev    = nb;
        ram_we     = 1'b1;
        ram_waddr  = hb.next;
        ram_wdata  = wr;
        state_next = S_AB_RD;
      end

      S_AB_RD: begin
        ram_raddr  = blk;
        state_next = S_AB_W;
      end

      S_AB_W: begin
        wr       = rd;
        wr.valid = 1'b1;
        wr.tag   = op.new_tag;
        wr.owner = op.owner_handle;
        if (split) begin
          wr.next = nb;
          wr.size = chunks[ADDR_W-1:0];
        end
        ram_we     = 1'b1;
        ram_waddr  = blk;
        ram_wdata  = wr;
        rover_next = wr.next;
        c_res_next = done_res(ST_OK, blk + 1'b1, op.owner_handle, '0);
        state_next = S_EMIT;
      end

      // Tag-range free: one pass over the list from chunk 0.
      S_FR_B: begin
        hb_next = rd;
        if (in_range) begin
          sp_next    = rd.prev;
          cur_next   = blk;
          h_next     = blk;
          ret_next   = S_FR_AFT;
          state_next = S_REL_EMIT;
        end else if (rd.next == '0) begin
          c_res_next = done_res(ST_OK, '0, '0, '0);
          state_next = S_EMIT;
        end else begin
          blk_next  = rd.next;
          ram_raddr = rd.next;
        end
      end

      S_FR_AFT: begin
        ram_raddr  = sp;
        state_next = S_FR_AF2;
      end

      S_FR_AF2: begin
        blk_next   = sel;
        ram_raddr  = sel;
        state_next = S_FR_NX;
      end

      S_FR_NX: begin
        if (rd.next == '0) begin
          c_res_next = done_res(ST_OK, '0, '0, '0);
          state_next = S_EMIT;
        end else begin
          blk_next   = rd.next;
          ram_raddr  = rd.next;
          state_next = S_FR_B;
        end
      end

      // Free, change tag and read tag on an addressed block.
      S_FIND: begin
        if (!rd.valid) begin
          c_res_next = done_res(ST_NOT_BLOCK, '0, '0, '0);
          state_next = S_EMIT;
        end else begin
          case (op.action)
            ACT_FREE: begin
              if (rd.tag >= cfg.max_tag) begin
                c_res_next = done_res(ST_BAD_TAG, '0, '0, '0);
                state_next = S_EMIT;
              end else begin
                hb_next    = rd;
                ret_next   = S_DONE_OK;
                state_next = S_REL_EMIT;
              end
            end
            ACT_CHANGE_TAG: begin
              if (op.new_tag == '0 || op.new_tag >= cfg.max_tag) begin
                c_res_next = done_res(ST_BAD_TAG, '0, '0, '0);
              end else if (op.new_tag >= cfg.purge && rd.owner == '0) begin
                c_res_next = done_res(ST_NEED_OWNER, '0, '0, '0);
              end else begin
                wr        = rd;
                wr.tag    = op.new_tag;
                ram_we    = 1'b1;
                ram_waddr = h;
                ram_wdata = wr;
                c_res_next = done_res(ST_OK, '0, '0, '0);
              end
              state_next = S_EMIT;
            end
            default: begin
              c_res_next = done_res(ST_OK, '0, '0, rd.tag);
              state_next = S_EMIT;
            end
          endcase
        end
      end

      S_DONE_OK: begin
        c_res_next = done_res(ST_OK, '0, '0, '0);
        state_next = S_EMIT;
      end

      // Release of block h (header in hb): report the owner first.
      S_REL_EMIT: begin
        if (hb.owner != '0 && cnt != OWNER_RES_MAX) begin
          emit_valid     = 1'b1;
          emit.kind      = KIND_OWNER;
          emit.address   = h + 1'b1;
          emit.owner     = hb.owner;
          emit.tag       = '0;
          emit.status    = ST_OK;
          emit.last      = 1'b0;
          if (emit_ready) begin
            cnt_next   = cnt + 1'b1;
            state_next = S_REL_W0;
          end
        end else begin
          state_next = S_REL_W0;
        end
      end

      S_REL_W0: begin
        wr         = hb;
        wr.owner   = '0;
        wr.valid   = 1'b0;
        wr.tag     = '0;
        hb_next    = wr;
        ram_we     = 1'b1;
        ram_waddr  = h;
        ram_wdata  = wr;
        if (h == '0) begin
          ram_raddr  = hb.next;
          state_next = S_REL_N;
        end else begin
          ram_raddr  = hb.prev;
          state_next = S_REL_P;
        end
      end

      // Merge into a free predecessor.
      S_REL_P: begin
        if (rd.tag != '0) begin
          ram_raddr  = hb.next;
          state_next = S_REL_N;
        end else begin
          wr         = rd;
          wr.next    = hb.next;
          wr.size    = rd.size + hb.size + 1'b1;
          ram_we     = 1'b1;
          ram_waddr  = hb.prev;
          ram_wdata  = wr;
          if (rover == h) begin
            rover_next = hb.prev;
          end
          nx_next    = hb.next;
          h_next     = hb.prev;
          state_next = S_REL_NPR;
        end
      end

      S_REL_NPR: begin
        ram_raddr  = nx;
        state_next = S_REL_NPW;
      end

      S_REL_NPW: begin
        wr         = rd;
        wr.prev    = h;
        ram_we     = 1'b1;
        ram_waddr  = nx;
        ram_wdata  = wr;
        state_next = S_REL_RH;
      end

      S_REL_RH: begin
        ram_raddr  = h;
        state_next = S_REL_H;
      end

      S_REL_H: begin
        hb_next    = rd;
        ram_raddr  = rd.next;
        state_next = S_REL_N;
      end

      // Absorb a free successor, unless it is chunk 0.
      S_REL_N: begin
        if (rd.tag == '0 && hb.next != '0) begin
          wr         = hb;
          wr.next    = rd.next;
          wr.size    = hb.size + rd.size + 1'b1;
          ram_we     = 1'b1;
          ram_waddr  = h;
          ram_wdata  = wr;
          if (rover == hb.next) begin
            rover_next = h;
          end
          nx_next    = rd.next;
          state_next = S_REL_NNR;
        end else begin
          state_next = ret;
        end
      end

      S_REL_NNR: begin
        ram_raddr  = nx;
        state_next = S_REL_NNW;
      end

      S_REL_NNW: begin
        wr         = rd;
        wr.prev    = h;
        ram_we     = 1'b1;
        ram_waddr  = nx;
        ram_wdata  = wr;
        state_next = ret;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A pool size write rebuilds the heap.
    if (restart) begin
      state_next = S_CLR;
      clr_next   = '0;
      rover_next = '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    restart |=> state == S_CLR)
    else $error("pool write did not start the clearing pass");

  a_owner_not_last: assert property (@(posedge clk) disable iff (rst)
    emit_valid && emit.kind == KIND_OWNER |-> !emit.last)
    else $error("owner cleared item marked last");

  a_rover_in_pool: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> {1'b0, rover} < cfg.pool)
    else $error("rover outside the pool");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we)
    else $error("header write while idle");
`endif

endmodule

`default_nettype wire

### rtl/core/tagged_first_fit_heap.sv
// ----------------------------------------------------------------------------
// tagged_first_fit_heap
// Tagged first-fit chunk allocator with a roving pointer and coalescing.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready); each request yields zero or
// more owner cleared items and then one completion item with last set, on
// rsp (valid/ready). Configuration is written on cfg_we/cfg_index/cfg_data
// while no request is in flight.
// One request is handled at a time. The headers live in one memory with a
// single read and a single write port. An alloc walks the block list from
// the rover and a tag-range free walks it from chunk 0; each released block
// and each split adds header accesses, so the length of the block list and
// the blocks released set how long a request takes.
// After reset, and after every pool_chunks write, a clearing pass writes all
// 128 headers while req.ready stays low.
// Results sit in an output register; while the receiver stalls the
// sequencer waits before emitting the next item, and req.ready is high only
// when the previous request has handed its completion to that register.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_first_fit_heap (
  input  wire logic                               clk,
  input  wire logic                               rst,
  tffh_req_if.sink                                req,
  tffh_rsp_if.source                              rsp,
  input  wire logic                               cfg_we,
  input  wire logic [tffh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tffh_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tffh_pkg::*;

  logic [POOL_W-1:0] pool_chunks;
  logic [TAG_W-1:0]  purge_level, max_tag;
  cfg_t              cfg;
  logic              restart, take, idle;
  logic              emit_valid, emit_ready;
  result_t           emit, res;
  req_t              req_item;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  header_t           ram_wdata, ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_chunks <= POOL_W'(POOL_CHUNKS);
      purge_level <= TAG_W'(100);
      max_tag     <= TAG_W'(101);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POOL:  pool_chunks <= POOL_W'(cfg_data);
        CFG_PURGE: purge_level <= TAG_W'(cfg_data);
        CFG_MAXT:  max_tag     <= TAG_W'(cfg_data);
        default:   ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_index == CFG_POOL);

  // Saturated register values.
  always_comb begin
    cfg.pool = pool_chunks;
    if (pool_chunks < POOL_W'(2)) begin
      cfg.pool = POOL_W'(2);
    end else if (pool_chunks > POOL_W'(POOL_CHUNKS)) begin
      cfg.pool = POOL_W'(POOL_CHUNKS);
    end
    cfg.purge   = (purge_level == '0) ? TAG_W'(1) : purge_level;
    cfg.max_tag = (max_tag < TAG_W'(2)) ? TAG_W'(2) : max_tag;
  end

  // Request side.
  assign req.ready = idle;
  assign take      = req.valid && idle;

  assign req_item.action       = req.action;
  assign req_item.size_bytes   = req.size_bytes;
  assign req_item.data_address = req.data_address;
  assign req_item.new_tag      = req.new_tag;
  assign req_item.owner_handle = req.owner_handle;
  assign req_item.tag_low      = req.tag_low;
  assign req_item.tag_high     = req.tag_high;

  tffh_ram #(
    .WIDTH (HDR_W),
    .DEPTH (POOL_CHUNKS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tffh_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .restart    (restart),
    .take       (take),
    .req        (req_item),
    .idle       (idle),
    .emit_valid (emit_valid),
    .emit       (emit),
    .emit_ready (emit_ready),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Output register.
  assign emit_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit_ready) begin
      rsp.valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      res <= emit;
    end
  end

  assign rsp.result_kind    = res.kind;
  assign rsp.result_address = res.address;
  assign rsp.result_owner   = res.owner;
  assign rsp.result_tag     = res.tag;
  assign rsp.status         = res.status;
  assign rsp.last           = res.last;

endmodule

`default_nettype wire

### tb/sv/tb_tagged_first_fit_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tagged_first_fit_heap
// Self-checking bench for the tagged first-fit heap. A directed table covers
// the rejected requests, the size extremes and the unknown actions. Random
// requests follow over several register settings, mostly aimed at live
// blocks. Every result item is compared with a behavioral heap kept in step
// with the accepted requests.
// ----------------------------------------------------------------------------
module tb_tagged_first_fit_heap;
  import tffh_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_C = 3'd7;

  typedef struct {
    req_t    r;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tffh_req_if req_ch ();
  tffh_rsp_if rsp_ch ();

  tagged_first_fit_heap u_top (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Behavioral heap: one header per chunk, plus rover and raw registers.
  bit hv[POOL_CHUNKS];
  int htag[POOL_CHUNKS];
  int hsize[POOL_CHUNKS];
  int hnxt[POOL_CHUNKS];
  int hprv[POOL_CHUNKS];
  int hown[POOL_CHUNKS];
  int rover;
  int reg_pool, reg_purge, reg_max;

  result_t heap_results[$];
  int step_n;
  int errors = 0;
  bit no_idle = 1'b0;

  function automatic int pool_eff();
    return reg_pool < 2 ? 2 : (reg_pool > POOL_CHUNKS ? POOL_CHUNKS : reg_pool);
  endfunction
  function automatic int purge_eff();
    return reg_purge < 1 ? 1 : reg_purge;
  endfunction
  function automatic int max_eff();
    return reg_max < 2 ? 2 : reg_max;
  endfunction

  function automatic void heap_init();
    for (int i = 0; i < POOL_CHUNKS; i++) begin
      hv[i] = 0; htag[i] = 0; hsize[i] = 0; hnxt[i] = 0; hprv[i] = 0; hown[i] = 0;
    end
    hsize[0] = pool_eff() - 1;
    rover = 0;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    if (idx == CFG_POOL) begin
      reg_pool = val & 8'hFF;
      heap_init();
    end else if (idx == CFG_PURGE) begin
      reg_purge = val & 7'h7F;
    end else if (idx == CFG_MAXT) begin
      reg_max = val & 7'h7F;
    end
  endfunction

  // Results beyond the per-request cap are silently lost.
  function automatic void put(logic kind, int addr, int own, int tag, status_e st,
                              logic last);
    result_t r;
    if (step_n >= MAX_RESULTS) return;
    r.kind = kind;
    r.address = ADDR_W'(addr);
    r.owner = OWNER_W'(own);
    r.tag = TAG_W'(tag);
    r.status = st;
    r.last = last;
    heap_results.push_back(r);
    step_n++;
  endfunction

  function automatic bit purgable(int h);
    return hv[h] && htag[h] >= purge_eff() && htag[h] < max_eff();
  endfunction

  // Frees a block, reports its owner and merges with free neighbors.
  function automatic void heap_release(int h);
    int o;
    if (hown[h] != 0) begin
      if (step_n < MAX_RESULTS - 1) put(KIND_OWNER, h + 1, hown[h], 0, ST_OK, 1'b0);
      hown[h] = 0;
    end
    hv[h] = 0;
    htag[h] = 0;
    if (h != 0) begin
      o = hprv[h];
      if (htag[o] == 0) begin
        if (rover == h) rover = o;
        hnxt[o] = hnxt[h];
        hprv[hnxt[h]] = o;
        hsize[o] += hsize[h] + 1;
        h = o;
      end
    end
    o = hnxt[h];
    if (htag[o] == 0 && o != 0) begin
      if (rover == o) rover = h;
      hnxt[h] = hnxt[o];
      hprv[hnxt[h]] = h;
      hsize[h] += hsize[o] + 1;
    end
  endfunction

  function automatic void heap_alloc(int bytes, int tag, int own);
    int chunks, blk, start, extra, nb, guard;
    int limit;
    limit = POOL_CHUNKS * (POOL_CHUNKS + 2);
    guard = 0;
    if (tag == 0 || tag >= max_eff()) begin
      put(KIND_DONE, 0, 0, 0, ST_BAD_TAG, 1'b1); return;
    end
    if (tag >= purge_eff() && own == 0) begin
      put(KIND_DONE, 0, 0, 0, ST_NEED_OWNER, 1'b1); return;
    end
    if (bytes == 0) begin
      put(KIND_DONE, 0, 0, 0, ST_OK, 1'b1); return;
    end
    chunks = (bytes + CHUNK_BYTES - 1) / CHUNK_BYTES;
    blk = rover;
    if (htag[hprv[blk]] == 0) blk = hprv[blk];
    start = blk;
    do begin
      if (purgable(blk)) begin
        start = hprv[blk];
        heap_release(blk);
        if (hnxt[start] == blk) start = blk;
        else blk = start;
      end
      if (htag[blk] == 0 && hsize[blk] >= chunks) begin
        extra = hsize[blk] - chunks;
        if (extra >= SPLIT_MIN_CHUNKS + 1) begin
          nb = blk + 1 + chunks;
          hnxt[nb] = hnxt[blk];
          hprv[hnxt[blk]] = nb;
          hprv[nb] = blk;
          hnxt[blk] = nb;
          hsize[blk] = chunks;
          hsize[nb] = extra - 1;
          htag[nb] = 0; hv[nb] = 0; hown[nb] = 0;
        end
        rover = hnxt[blk];
        hv[blk] = 1;
        htag[blk] = tag;
        hown[blk] = own;
        put(KIND_DONE, blk + 1, own, 0, ST_OK, 1'b1);
        return;
      end
      blk = hnxt[blk];
      guard++;
    end while (blk != start && guard < limit);
    put(KIND_DONE, 0, 0, 0, ST_NO_MEM, 1'b1);
  endfunction

  function automatic void heap_free_range(int lo, int hi);
    int blk, prv, cur;
    blk = 0;
    if (lo < 1) lo = 1;
    do begin
      if (hv[blk] && htag[blk] >= lo && htag[blk] <= hi && htag[blk] < max_eff()) begin
        prv = hprv[blk];
        cur = blk;
        heap_release(blk);
        blk = (hnxt[prv] == cur) ? cur : prv;
      end
      blk = hnxt[blk];
    end while (blk != 0);
    put(KIND_DONE, 0, 0, 0, ST_OK, 1'b1);
  endfunction

  function automatic bit is_block(int da);
    return da != 0 && da - 1 < pool_eff() && hv[da - 1];
  endfunction

  // Updates the heap for one accepted request and queues its results.
  function automatic void heap_predict(req_t r);
    int da, h, nt;
    da = r.data_address;
    h = da - 1;
    nt = r.new_tag;
    step_n = 0;
    case (r.action)
      ACT_ALLOC: heap_alloc(r.size_bytes, nt, r.owner_handle);
      ACT_FREE: begin
        if (!is_block(da)) put(KIND_DONE, 0, 0, 0, ST_NOT_BLOCK, 1'b1);
        else if (htag[h] >= max_eff()) put(KIND_DONE, 0, 0, 0, ST_BAD_TAG, 1'b1);
        else begin
          heap_release(h);
          put(KIND_DONE, 0, 0, 0, ST_OK, 1'b1);
        end
      end
      ACT_FREE_RANGE: heap_free_range(r.tag_low, r.tag_high);
      ACT_CHANGE_TAG: begin
        if (!is_block(da)) put(KIND_DONE, 0, 0, 0, ST_NOT_BLOCK, 1'b1);
        else if (nt == 0 || nt >= max_eff()) put(KIND_DONE, 0, 0, 0, ST_BAD_TAG, 1'b1);
        else if (nt >= purge_eff() && hown[h] == 0)
          put(KIND_DONE, 0, 0, 0, ST_NEED_OWNER, 1'b1);
        else begin
          htag[h] = nt;
          put(KIND_DONE, 0, 0, 0, ST_OK, 1'b1);
        end
      end
      ACT_READ_TAG: begin
        if (!is_block(da)) put(KIND_DONE, 0, 0, 0, ST_NOT_BLOCK, 1'b1);
        else put(KIND_DONE, 0, 0, htag[h], ST_OK, 1'b1);
      end
      default: put(KIND_DONE, 0, 0, 0, ST_OK, 1'b1);
    endcase
  endfunction

  function automatic dir_row_t row(logic [ACT_W-1:0] act, int sz, int da, int nt,
                                   int own, int lo, int hi, bit typed, int waddr,
                                   int wown, int wtag, status_e wst);
    dir_row_t d;
    d.r.action = act;
    d.r.size_bytes = SIZE_W'(sz);
    d.r.data_address = ADDR_W'(da);
    d.r.new_tag = TAG_W'(nt);
    d.r.owner_handle = OWNER_W'(own);
    d.r.tag_low = TAG_W'(lo);
    d.r.tag_high = TAG_W'(hi);
    d.typed = typed;
    d.want.kind = KIND_DONE;
    d.want.address = ADDR_W'(waddr);
    d.want.owner = OWNER_W'(wown);
    d.want.tag = TAG_W'(wtag);
    d.want.status = wst;
    d.want.last = 1'b1;
    return d;
  endfunction

  // Picks the data address of a live block, or any address if none or at random one time in ten.
  function automatic int pick_live();
    int live[$];
    for (int i = 0; i < pool_eff(); i++) if (hv[i]) live.push_back(i + 1);
    if (live.size() == 0 || $urandom_range(9) == 0) return $urandom_range(127);
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic int pick_tag();
    if ($urandom_range(6) == 0) return $urandom_range(127);
    return $urandom_range(1, max_eff() - 1);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int roll;
    roll = $urandom_range(99);
    r = req_t'($bits(req_t)'({$urandom, $urandom}));
    if (roll < 40) begin
      r.action = ACT_ALLOC;
      r.size_bytes = SIZE_W'(($urandom_range(4) == 0) ? $urandom_range(4095) :
                                                        $urandom_range(1, 160));
      r.new_tag = TAG_W'(pick_tag());
      if (r.new_tag >= purge_eff() && $urandom_range(9) != 0)
        r.owner_handle = OWNER_W'($urandom_range(1, 255));
    end else if (roll < 62) begin
      r.action = ACT_FREE;
      r.data_address = ADDR_W'(pick_live());
    end else if (roll < 70) begin
      r.action = ACT_FREE_RANGE;
    end else if (roll < 82) begin
      r.action = ACT_CHANGE_TAG;
      r.data_address = ADDR_W'(pick_live());
      r.new_tag = TAG_W'(pick_tag());
    end else if (roll < 94) begin
      r.action = ACT_READ_TAG;
      r.data_address = ADDR_W'(pick_live());
    end
    return r;
  endfunction

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(99);
    if (no_idle || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item, waits for the handshake and then predicts its results.
  task automatic send(req_t r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= r.action;
    req_ch.size_bytes <= r.size_bytes;
    req_ch.data_address <= r.data_address;
    req_ch.new_tag <= r.new_tag;
    req_ch.owner_handle <= r.owner_handle;
    req_ch.tag_low <= r.tag_low;
    req_ch.tag_high <= r.tag_high;
    do @(posedge clk); while (!req_ch.ready);
    heap_predict(r);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    apply_cfg(idx, val);
  endtask

  // Waits until every expected item has come, plus some settling time.
  task automatic drain();
    while (heap_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report(string what, int got, int want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Result side: checks each item and stalls at random, once for a long hold.
  int rsp_stall = 0;
  int rsp_seen = 0;
  initial rsp_ch.ready = 1'b0;
  always @(posedge clk) begin
    result_t w;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_seen++;
      if (heap_results.size() == 0) begin
        report("unexpected result item, kind", rsp_ch.result_kind, -1);
      end else begin
        w = heap_results.pop_front();
        if (rsp_ch.result_kind !== w.kind) report("result_kind", rsp_ch.result_kind, w.kind);
        if (rsp_ch.result_address !== w.address)
          report("result_address", rsp_ch.result_address, w.address);
        if (rsp_ch.result_owner !== w.owner)
          report("result_owner", rsp_ch.result_owner, w.owner);
        if (rsp_ch.result_tag !== w.tag) report("result_tag", rsp_ch.result_tag, w.tag);
        if (rsp_ch.status !== w.status) report("status", rsp_ch.status, w.status);
        if (rsp_ch.last !== w.last) report("last", rsp_ch.last, w.last);
      end
    end
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_seen == 150 && rsp_ch.valid && rsp_ch.ready) begin
      rsp_stall = HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ch.ready <= 1'b0;
    end else if (no_idle || $urandom_range(99) < 70) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      rsp_stall = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      rsp_ch.ready <= 1'b0;
    end
  end

  // Watchdog on cycles with no handshake on either side.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("tagged_first_fit_heap test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    dir_row_t dir_rows[$];
    result_t typed_res;
    req_valid_init: begin
      req_ch.valid <= 1'b0;
      req_ch.action <= ACT_ALLOC;
      req_ch.size_bytes <= '0;
      req_ch.data_address <= '0;
      req_ch.new_tag <= '0;
      req_ch.owner_handle <= '0;
      req_ch.tag_low <= '0;
      req_ch.tag_high <= '0;
      cfg_we <= 1'b0;
      cfg_index <= CFG_POOL;
      cfg_data <= '0;
    end
    reg_pool = 128; reg_purge = 100; reg_max = 101;
    heap_init();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Default registers: pool 128, purge level 100, max tag 101.
    dir_rows.push_back(row(ACT_ALLOC, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_ALLOC, 32, 0, 0, 3, 0, 0, 1, 0, 0, 0, ST_BAD_TAG));
    dir_rows.push_back(row(ACT_ALLOC, 32, 0, 101, 3, 0, 0, 1, 0, 0, 0, ST_BAD_TAG));
    dir_rows.push_back(row(ACT_ALLOC, 32, 0, 100, 0, 0, 0, 1, 0, 0, 0, ST_NEED_OWNER));
    dir_rows.push_back(row(ACT_ALLOC, 4095, 0, 1, 0, 0, 0, 1, 0, 0, 0, ST_NO_MEM));
    dir_rows.push_back(row(ACT_ALLOC, 1, 0, 1, 7, 0, 0, 1, 1, 7, 0, ST_OK));
    dir_rows.push_back(row(ACT_READ_TAG, 0, 1, 0, 0, 0, 0, 1, 0, 0, 1, ST_OK));
    dir_rows.push_back(row(ACT_ALLOC, 100, 0, 100, 255, 0, 0, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_ALLOC, 64, 0, 5, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_FREE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, ST_NOT_BLOCK));
    dir_rows.push_back(row(ACT_FREE, 0, 127, 0, 0, 0, 0, 1, 0, 0, 0, ST_NOT_BLOCK));
    dir_rows.push_back(row(ACT_FREE, 0, 2, 0, 0, 0, 0, 1, 0, 0, 0, ST_NOT_BLOCK));
    dir_rows.push_back(row(ACT_CHANGE_TAG, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0, ST_BAD_TAG));
    dir_rows.push_back(row(ACT_CHANGE_TAG, 0, 1, 127, 0, 0, 0, 1, 0, 0, 0, ST_BAD_TAG));
    dir_rows.push_back(row(ACT_CHANGE_TAG, 0, 8, 100, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_CHANGE_TAG, 0, 1, 100, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_ALLOC, 4095, 0, 50, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_FREE, 0, 8, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_FREE, 0, 8, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_ALLOC, 2000, 0, 99, 170, 0, 0, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_ALLOC, 4000, 0, 100, 85, 0, 0, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_FREE_RANGE, 0, 0, 0, 0, 0, 127, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_RSVD_A, 4095, 127, 127, 255, 127, 127, 1, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_RSVD_B, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, ST_OK));
    dir_rows.push_back(row(ACT_RSVD_C, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, ST_OK));

    foreach (dir_rows[i]) begin
      send(dir_rows[i].r);
      if (dir_rows[i].typed) begin
        typed_res = dir_rows[i].want;
        heap_results[heap_results.size() - 1] = typed_res;
      end
    end

    // Random phases; register writes happen only with the block drained.
    for (int ph = 1; ph <= 6; ph++) begin
      int n_items;
      if (ph > 1) begin
        req_ch.valid <= 1'b0;
        drain();
        case (ph)
          2: begin write_cfg(CFG_MAXT, 60); write_cfg(CFG_PURGE, 40); end
          3: begin write_cfg(CFG_POOL, 2); write_cfg(CFG_PURGE, 1); write_cfg(CFG_MAXT, 2); end
          4: begin
            write_cfg(CFG_POOL, 255); write_cfg(CFG_PURGE, 127); write_cfg(CFG_MAXT, 127);
          end
          5: begin write_cfg(CFG_POOL, 40); write_cfg(CFG_PURGE, 0); write_cfg(CFG_MAXT, 0); end
          default: begin
            write_cfg(CFG_POOL, 128); write_cfg(CFG_PURGE, 100); write_cfg(CFG_MAXT, 101);
          end
        endcase
        cfg_we <= 1'b0;
      end
      no_idle = (ph == 4);
      case (ph)
        1: n_items = 80;
        2: n_items = 60;
        3: n_items = 30;
        4: n_items = 80;
        5: n_items = 40;
        default: n_items = 130;
      endcase
      for (int k = 0; k < n_items; k++) send(random_request());
    end

    req_ch.valid <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("tagged_first_fit_heap test passed");
    end else begin
      $display("tagged_first_fit_heap test failed");
    end
    $finish;
  end

endmodule

### tagged_first_fit_heap.f
rtl/core/tffh_pkg.sv
rtl/core/tffh_if.sv
rtl/core/tffh_ram.sv
rtl/core/tffh_seq.sv
rtl/core/tagged_first_fit_heap.sv
tb/sv/tb_tagged_first_fit_heap.sv
